FILE: rtl/core/sla_pkg.sv
// Package: sizes, character codes and helpers for the serial line assembler.
`timescale 1ns / 1ps

package sla_pkg;

  // Ring and line sizes
  localparam int unsigned LINE_MAX    = 256;
  localparam int unsigned QUEUE_DEPTH = 16;

  // Derived widths
  localparam int unsigned IDX_W  = $clog2(LINE_MAX);          // byte index in a line
  localparam int unsigned LEN_W  = $clog2(LINE_MAX + 1);      // line length, 0..LINE_MAX
  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);       // slot index
  localparam int unsigned CNT_W  = 5;                         // lines_queued port width
  localparam int unsigned SADR_W = SLOT_W + IDX_W;            // line store address
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DROP_W = 32;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'd126;

  // Item modes
  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Map a received byte to the byte kept in the line
  function automatic logic [BYTE_W-1:0] printable(input logic [BYTE_W-1:0] b);
    logic ok;
    ok = (b >= PRINT_LOW) && (b <= PRINT_HIGH);
    return ok ? b : CHAR_DOT;
  endfunction

  // True for CR or LF
  function automatic logic is_eol(input logic [BYTE_W-1:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

endpackage

FILE: rtl/core/serial_line_assembler_queue.sv
// Top level: serial line assembler with a ring of finished lines in block memories.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------------------
//  command  | start_i, busy_o               | mode_i, rx_byte_i
//  result   | done_o (one-cycle strobe)     | line_valid_o, line_byte_o, line_last_o,
//           |                               | lines_queued_o, lines_dropped_o
//
// A printable byte, an ignored byte, a dropped line or a read of an empty ring
// returns its result in the cycle after the command; a read of a queued byte first
// waits in ST_READ for the slot memory's registered read. A line end that queues a
// line copies it in ST_COPY, one byte per cycle through the assembly memory's read
// port, then writes the last byte read and commits the slot. busy_o is high meanwhile.
// Reset clears counters and pointers, not the memories; results cannot be held off.
`timescale 1ns / 1ps

module serial_line_assembler_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                mode_i,
  input  logic [sla_pkg::BYTE_W-1:0]          rx_byte_i,
  output logic                                done_o,
  output logic                                line_valid_o,
  output logic [sla_pkg::BYTE_W-1:0]          line_byte_o,
  output logic                                line_last_o,
  output logic [sla_pkg::CNT_W-1:0]           lines_queued_o,
  output logic [sla_pkg::DROP_W-1:0]          lines_dropped_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  // Control state
  logic [1:0]                      state_q, state_d;
  logic [sla_pkg::LEN_W-1:0]       asm_len_q, asm_len_d;
  logic [sla_pkg::LEN_W-1:0]       cp_q, cp_d;
  logic                            pend_q, pend_d;
  logic [sla_pkg::IDX_W-1:0]       widx_q, widx_d;
  logic [sla_pkg::SLOT_W-1:0]      ws_q, ws_d;
  logic [sla_pkg::SLOT_W-1:0]      rs_q, rs_d;
  logic [sla_pkg::IDX_W-1:0]       off_q, off_d;
  logic [sla_pkg::CNT_W-1:0]       count_q, count_d;
  logic [sla_pkg::DROP_W-1:0]      drop_q, drop_d;
  logic                            done_q, done_d;
  logic                            valid_q, valid_d;
  logic [sla_pkg::BYTE_W-1:0]      byte_q, byte_d;
  logic                            last_q, last_d;

  // Memories
  logic [sla_pkg::BYTE_W-1:0]      asm_mem  [sla_pkg::LINE_MAX];
  logic [sla_pkg::BYTE_W-1:0]      slot_mem [2**sla_pkg::SADR_W];
  logic [sla_pkg::LEN_W-1:0]       len_mem  [sla_pkg::QUEUE_DEPTH];
  logic [sla_pkg::BYTE_W-1:0]      asm_rdata_q;
  logic [sla_pkg::BYTE_W-1:0]      slot_rdata_q;
  logic [sla_pkg::LEN_W-1:0]       len_rdata_q;

  logic                            asm_we;
  logic [sla_pkg::IDX_W-1:0]       asm_waddr;
  logic [sla_pkg::BYTE_W-1:0]      asm_wdata;
  logic [sla_pkg::IDX_W-1:0]       asm_raddr;
  logic                            slot_we;
  logic                            len_we;

  logic                            accept;
  logic                            rd_en;
  logic [sla_pkg::LEN_W-1:0]       off_next;
  logic [sla_pkg::SLOT_W-1:0]      ws_inc;
  logic [sla_pkg::SLOT_W-1:0]      rs_inc;

  assign accept = start_i && (state_q == ST_IDLE);
  assign rd_en  = (state_q == ST_COPY) && (cp_q < asm_len_q);

  assign ws_inc = (ws_q == sla_pkg::SLOT_W'(sla_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : ws_q + 1'b1;
  assign rs_inc = (rs_q == sla_pkg::SLOT_W'(sla_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rs_q + 1'b1;
  assign off_next = sla_pkg::LEN_W'(off_q) + 1'b1;

  // Memory port controls
  assign asm_we    = accept && (mode_i == sla_pkg::MODE_RX) && !sla_pkg::is_eol(rx_byte_i)
                     && (asm_len_q < sla_pkg::LEN_W'(sla_pkg::LINE_MAX));
  assign asm_waddr = asm_len_q[sla_pkg::IDX_W-1:0];
  assign asm_wdata = sla_pkg::printable(rx_byte_i);
  assign asm_raddr = cp_q[sla_pkg::IDX_W-1:0];
  assign slot_we   = (state_q == ST_COPY) && pend_q;
  assign len_we    = (state_q == ST_COPY) && !rd_en && !pend_q;

  // Assembly buffer: written per received byte, read during the copy
  always_ff @(posedge clk_i) begin
    if (asm_we) begin
      asm_mem[asm_waddr] <= asm_wdata;
    end
    asm_rdata_q <= asm_mem[asm_raddr];
  end

  // Line store: written by the copy, read at the oldest line's read offset
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[{ws_q, widx_q}] <= asm_rdata_q;
    end
    slot_rdata_q <= slot_mem[{rs_q, off_q}];
  end

  // Slot lengths: written when the copy completes
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[ws_q] <= asm_len_q;
    end
    len_rdata_q <= len_mem[rs_q];
  end

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    asm_len_d = asm_len_q;
    cp_d      = cp_q;
    pend_d    = 1'b0;
    widx_d    = cp_q[sla_pkg::IDX_W-1:0];
    ws_d      = ws_q;
    rs_d      = rs_q;
    off_d     = off_q;
    count_d   = count_q;
    drop_d    = drop_q;
    done_d    = 1'b0;
    valid_d   = valid_q;
    byte_d    = byte_q;
    last_d    = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == sla_pkg::MODE_RX) begin
            if (sla_pkg::is_eol(rx_byte_i)) begin
              if (asm_len_q != '0) begin
                if (count_q < sla_pkg::CNT_W'(sla_pkg::QUEUE_DEPTH)) begin
                  // start copying the line into the write slot
                  state_d = ST_COPY;
                  cp_d    = '0;
                end else begin
                  drop_d    = drop_q + 1'b1;
                  asm_len_d = '0;
                  done_d    = 1'b1;
                  valid_d   = 1'b0;
                  byte_d    = '0;
                  last_d    = 1'b0;
                end
              end else begin
                done_d  = 1'b1;
                valid_d = 1'b0;
                byte_d  = '0;
                last_d  = 1'b0;
              end
            end else begin
              if (asm_we) begin
                asm_len_d = asm_len_q + 1'b1;
              end
              done_d  = 1'b1;
              valid_d = 1'b0;
              byte_d  = '0;
              last_d  = 1'b0;
            end
          end else if (count_q != '0) begin
            // memories are read at {rs, off} this cycle
            state_d = ST_READ;
          end else begin
            done_d  = 1'b1;
            valid_d = 1'b0;
            byte_d  = '0;
            last_d  = 1'b0;
          end
        end
      end

      ST_COPY: begin
        pend_d = rd_en;
        if (rd_en) begin
          cp_d = cp_q + 1'b1;
        end
        if (!rd_en && !pend_q) begin
          // all bytes written: commit the slot
          ws_d      = ws_inc;
          count_d   = count_q + 1'b1;
          asm_len_d = '0;
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          valid_d   = 1'b0;
          byte_d    = '0;
          last_d    = 1'b0;
        end
      end

      ST_READ: begin
        done_d  = 1'b1;
        valid_d = 1'b1;
        byte_d  = slot_rdata_q;
        state_d = ST_IDLE;
        if (off_next >= len_rdata_q) begin
          last_d  = 1'b1;
          off_d   = '0;
          rs_d    = rs_inc;
          count_d = count_q - 1'b1;
        end else begin
          last_d = 1'b0;
          off_d  = off_next[sla_pkg::IDX_W-1:0];
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      asm_len_q <= '0;
      cp_q      <= '0;
      pend_q    <= 1'b0;
      ws_q      <= '0;
      rs_q      <= '0;
      off_q     <= '0;
      count_q   <= '0;
      drop_q    <= '0;
      done_q    <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      asm_len_q <= asm_len_d;
      cp_q      <= cp_d;
      pend_q    <= pend_d;
      ws_q      <= ws_d;
      rs_q      <= rs_d;
      off_q     <= off_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    widx_q <= widx_d;
    byte_q <= byte_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign line_valid_o    = valid_q;
  assign line_byte_o     = byte_q;
  assign line_last_o     = last_q;
  assign lines_queued_o  = count_q;
  assign lines_dropped_o = drop_q;

endmodule

FILE: rtl/core/sla_checker.sv
// Checker: port-level properties of the serial line assembler, bound to the top level.
`timescale 1ns / 1ps

module sla_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         mode_i,
  input logic [sla_pkg::BYTE_W-1:0]   rx_byte_i,
  input logic                         done_o,
  input logic                         line_valid_o,
  input logic [sla_pkg::BYTE_W-1:0]   line_byte_o,
  input logic                         line_last_o,
  input logic [sla_pkg::CNT_W-1:0]    lines_queued_o,
  input logic [sla_pkg::DROP_W-1:0]   lines_dropped_o
);

  // A plain received byte completes in the next cycle
  a_byte_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == sla_pkg::MODE_RX) && (rx_byte_i != sla_pkg::CHAR_CR)
     && (rx_byte_i != sla_pkg::CHAR_LF)) |=> done_o)
    else $error("received byte did not complete in one cycle");

  // Last marker only on a valid byte, and invalid results carry a zero byte
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !line_valid_o) |-> (!line_last_o && (line_byte_o == '0)))
    else $error("invalid result carries data");

  // Queue occupancy never exceeds the ring depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_queued_o <= sla_pkg::CNT_W'(sla_pkg::QUEUE_DEPTH))
    else $error("queue occupancy out of range");

  // Drop counter only steps by one
  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(lines_dropped_o) |-> (lines_dropped_o == $past(lines_dropped_o) + 1'b1))
    else $error("drop counter jumped");

  // Freeing a slot lowers the occupancy by one
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(done_o) && line_last_o) |->
      (lines_queued_o == $past(lines_queued_o) - 1'b1))
    else $error("slot not freed on last byte");

endmodule

bind serial_line_assembler_queue sla_checker u_sla_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .mode_i          (mode_i),
  .rx_byte_i       (rx_byte_i),
  .done_o          (done_o),
  .line_valid_o    (line_valid_o),
  .line_byte_o     (line_byte_o),
  .line_last_o     (line_last_o),
  .lines_queued_o  (lines_queued_o),
  .lines_dropped_o (lines_dropped_o)
);

FILE: tb/tb_serial_line_assembler_queue.sv
// Testbench for serial_line_assembler_queue: random and directed transfers checked by a predictor.
`timescale 1ns / 1ps

module tb_serial_line_assembler_queue;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 300;    // longer than the slowest line copy

  typedef struct packed {
    logic                       valid;
    logic [sla_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic [sla_pkg::CNT_W-1:0]  queued;
    logic [sla_pkg::DROP_W-1:0] dropped;
  } line_result_t;

  // DUT ports
  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       mode_i;
  logic [sla_pkg::BYTE_W-1:0] rx_byte_i;
  logic                       done_o;
  logic                       line_valid_o;
  logic [sla_pkg::BYTE_W-1:0] line_byte_o;
  logic                       line_last_o;
  logic [sla_pkg::CNT_W-1:0]  lines_queued_o;
  logic [sla_pkg::DROP_W-1:0] lines_dropped_o;

  // Predicted state of the assembler and the ring
  logic [sla_pkg::BYTE_W-1:0] asm_buf [sla_pkg::LINE_MAX];
  int                         asm_len;
  logic [sla_pkg::BYTE_W-1:0] slot_mem [sla_pkg::QUEUE_DEPTH][sla_pkg::LINE_MAX];
  int                         slot_len [sla_pkg::QUEUE_DEPTH];
  int                         wr_slot;
  int                         rd_slot;
  int                         q_count;
  int                         rd_off;
  logic [sla_pkg::DROP_W-1:0] drop_count;

  line_result_t      outcome_q[$];
  line_result_t      oldest;
  int unsigned       errors;
  int unsigned       items_sent;
  int unsigned       cycle_count = 0;
  bit                no_gaps;

  serial_line_assembler_queue u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .done_o         (done_o),
    .line_valid_o   (line_valid_o),
    .line_byte_o    (line_byte_o),
    .line_last_o    (line_last_o),
    .lines_queued_o (lines_queued_o),
    .lines_dropped_o(lines_dropped_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Predictor: one accepted item in, one result out
  function automatic line_result_t assemble_and_read(input logic m,
                                                     input logic [sla_pkg::BYTE_W-1:0] b);
    line_result_t r;
    r = '0;
    if (m == sla_pkg::MODE_RX) begin
      if (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF) begin
        // line end: queue a non-empty line, or count it lost when the ring is full
        if (asm_len > 0) begin
          if (q_count < sla_pkg::QUEUE_DEPTH) begin
            for (int i = 0; i < asm_len; i++) slot_mem[wr_slot][i] = asm_buf[i];
            slot_len[wr_slot] = asm_len;
            wr_slot = (wr_slot + 1) % sla_pkg::QUEUE_DEPTH;
            q_count++;
          end else begin
            drop_count = drop_count + 1;
          end
          asm_len = 0;
        end
      end else if (asm_len < sla_pkg::LINE_MAX) begin
        asm_buf[asm_len] = (b >= sla_pkg::PRINT_LOW && b <= sla_pkg::PRINT_HIGH) ?
                           b : sla_pkg::CHAR_DOT;
        asm_len++;
      end
    end else if (q_count > 0) begin
      // read one byte of the oldest line; free its slot after the last one
      r.valid = 1'b1;
      r.data  = slot_mem[rd_slot][rd_off];
      if (rd_off + 1 >= slot_len[rd_slot]) begin
        r.last  = 1'b1;
        rd_off  = 0;
        rd_slot = (rd_slot + 1) % sla_pkg::QUEUE_DEPTH;
        q_count--;
      end else begin
        rd_off++;
      end
    end
    r.queued  = sla_pkg::CNT_W'(q_count);
    r.dropped = drop_count;
    return r;
  endfunction

  // Drive one item, wait for its transfer, record the predicted result
  task automatic send_item(input logic m, input logic [sla_pkg::BYTE_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   <= 1'b1;
    mode_i    <= m;
    rx_byte_i <= b;
    do @(posedge clk_i); while (busy_o);
    outcome_q.push_back(assemble_and_read(m, b));
    items_sent++;
  endtask

  // Random line content (never CR or LF), then a terminator
  task automatic send_line(input int len, input bit use_lf);
    logic [sla_pkg::BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      do b = sla_pkg::BYTE_W'($urandom_range(0, 255));
      while (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF);
      send_item(sla_pkg::MODE_RX, b);
    end
    send_item(sla_pkg::MODE_RX, use_lf ? sla_pkg::CHAR_LF : sla_pkg::CHAR_CR);
  endtask

  // Read until the ring is empty
  task automatic drain_ring();
    while (q_count > 0)
      send_item(sla_pkg::MODE_READ, sla_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Field check
  task automatic check_field(input string name, input logic [sla_pkg::DROP_W-1:0] exp_v,
                             input logic [sla_pkg::DROP_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %0h", $time, line_byte_o);
        errors++;
      end else begin
        oldest = outcome_q.pop_front();
        check_field("line_valid", oldest.valid, line_valid_o);
        check_field("line_byte", oldest.data, line_byte_o);
        check_field("line_last", oldest.last, line_last_o);
        check_field("lines_queued", oldest.queued, lines_queued_o);
        check_field("lines_dropped", oldest.dropped, lines_dropped_o);
      end
    end
  end

  // Field extremes, empty ring read, empty lines, short lines read back
  task automatic test_directed();
    no_gaps = 1'b0;
    send_item(sla_pkg::MODE_READ, 8'hFF);
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_CR);
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_LF);
    send_item(sla_pkg::MODE_RX, 8'h00);
    send_item(sla_pkg::MODE_RX, 8'h1F);
    send_item(sla_pkg::MODE_RX, sla_pkg::PRINT_LOW);
    send_item(sla_pkg::MODE_RX, sla_pkg::PRINT_HIGH);
    send_item(sla_pkg::MODE_RX, 8'h7F);
    send_item(sla_pkg::MODE_RX, 8'hFF);
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_CR);
    repeat (6) send_item(sla_pkg::MODE_READ, 8'h00);
    send_item(sla_pkg::MODE_READ, 8'h55);
    send_item(sla_pkg::MODE_RX, 8'h41);
    send_item(sla_pkg::MODE_RX, 8'h42);
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_LF);
    send_item(sla_pkg::MODE_RX, 8'h7A);
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_CR);
    repeat (3) send_item(sla_pkg::MODE_READ, 8'hAA);
  endtask

  // Fill the ring, lose lines while full, then read everything back
  task automatic test_ring_full();
    no_gaps = 1'b1;
    repeat (sla_pkg::QUEUE_DEPTH) send_line($urandom_range(1, 4), $urandom_range(0, 1));
    no_gaps = 1'b0;
    repeat (3) send_line($urandom_range(1, 3), $urandom_range(0, 1));
    send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_CR);
    drain_ring();
  endtask

  // A line longer than the slot keeps only its first bytes
  task automatic test_overlong();
    no_gaps = 1'b0;
    send_line(sla_pkg::LINE_MAX + 4, 1'b1);
    drain_ring();
  endtask

  // Mixed traffic: short lines, read bursts and raw noise
  task automatic test_random();
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      no_gaps = (((items_sent - first) / 100) % 4) == 3;
      pick = $urandom_range(0, 99);
      // first half favors lines so the ring fills up and loses some
      if (pick < ((items_sent - first < RANDOM_ITEMS / 2) ? 65 : 40)) begin
        send_line($urandom_range(1, 12), $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) send_item(sla_pkg::MODE_RX, sla_pkg::CHAR_LF);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 15))
          send_item(sla_pkg::MODE_READ, sla_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), sla_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
    drain_ring();
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = sla_pkg::MODE_RX;
    rx_byte_i   = '0;
    asm_len     = 0;
    wr_slot     = 0;
    rd_slot     = 0;
    q_count     = 0;
    rd_off      = 0;
    drop_count  = '0;
    errors      = 0;
    items_sent  = 0;
    no_gaps     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_ring_full();
    test_overlong();
    test_random();

    @(negedge clk_i);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
